// ===== design/assert_macros.svh =====
// Assertion macros shared by the lighting core RTL.
// No dependencies; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/tfnl_pkg.sv =====
// Package for the triangle face normal lighting core.
// Register addresses and fixed widths; no dependencies.
package tfnl_pkg;
  localparam int LightW = 16;
  localparam int FloorW = 15;
  localparam int OutW   = 16;
  localparam int AddrW  = 4;

  typedef enum logic [1:0] {
    REG_LIGHT_X = 2'd0,
    REG_LIGHT_Y = 2'd1,
    REG_LIGHT_Z = 2'd2,
    REG_FLOOR   = 2'd3
  } reg_idx_t;
endpackage

// ===== design/triangle_face_normal_lighting_core.sv =====
// Triangle face normal and Lambert intensity, deep pipeline.
// Stages: edges, products, cross, magnitude, scale, squares, sum, one root bit
// and one quotient bit per stage, two dot stages, output.
// Throughput one item per cycle; a stall freezes every stage together.
// Synchronous active-high reset clears valid bits and loads register defaults.
`include "assert_macros.svh"
module triangle_face_normal_lighting_core #(
  parameter int COORD_WIDTH    = 16,
  parameter int NORM_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [tfnl_pkg::AddrW-1:0] paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // triangle requests
  input  logic         s_tvalid,
  output logic         s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, 16 bits each from bit 0
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // nx[15:0], ny[31:16], nz[47:32], intensity[62:48], degenerate[63]
  output logic [63:0]  m_tdata
);
  localparam int F   = NORM_FRAC_BITS;
  localparam int EW0 = COORD_WIDTH + 1;
  localparam int ES  = (EW0 > 31) ? EW0 - 31 : 0;
  localparam int EW  = EW0 - ES;
  localparam int CW  = 2 * EW + 1;
  localparam int SqW = 62;
  localparam int RW  = SqW / 2;
  localparam int NRT = RW;
  localparam int QW  = F + 2;
  localparam int NDV = QW;
  localparam int NW  = 30 + F + 1;
  localparam int PW  = QW + 17;
  localparam int CSW = $clog2(CW + 1) + 1;

  logic adv;

  // configuration registers
  logic signed [15:0] light_x, light_y, light_z;
  logic [14:0] ambient_floor;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
      light_z <= 16'sd16384;
      ambient_floor <= 15'd1638;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (tfnl_pkg::reg_idx_t'(paddr[3:2]))
        tfnl_pkg::REG_LIGHT_X: light_x <= pwdata[15:0];
        tfnl_pkg::REG_LIGHT_Y: light_y <= pwdata[15:0];
        tfnl_pkg::REG_LIGHT_Z: light_z <= pwdata[15:0];
        tfnl_pkg::REG_FLOOR:   ambient_floor <= pwdata[14:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = '0;
    unique case (tfnl_pkg::reg_idx_t'(paddr[3:2]))
      tfnl_pkg::REG_LIGHT_X: prdata = {16'd0, light_x};
      tfnl_pkg::REG_LIGHT_Y: prdata = {16'd0, light_y};
      tfnl_pkg::REG_LIGHT_Z: prdata = {16'd0, light_z};
      tfnl_pkg::REG_FLOOR:   prdata = {17'd0, ambient_floor};
      default: prdata = '0;
    endcase
  end

  // global stall: pipeline moves when the output slot is free
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: edges (field zero-extended, low COORD_WIDTH bits taken as signed)
  logic v1;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  function automatic logic signed [EW-1:0] edge_of(logic [31:0] p, logic [31:0] q);
    logic signed [EW0-1:0] d;
    logic [EW0-1:0] mg;
    d = EW0'(signed'(q[COORD_WIDTH-1:0])) - EW0'(signed'(p[COORD_WIDTH-1:0]));
    mg = d[EW0-1] ? -d : d;
    mg = mg >> ES;
    return d[EW0-1] ? -EW'(mg) : EW'(mg);
  endfunction
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) begin
      v1 <= s_tvalid;
      for (int i = 0; i < 3; i++) begin
        e1[i] <= edge_of(32'(s_tdata[16*i +: 16]), 32'(s_tdata[16*(3+i) +: 16]));
        e2[i] <= edge_of(32'(s_tdata[16*i +: 16]), 32'(s_tdata[16*(6+i) +: 16]));
      end
    end
  end

  // stage 2: products, stage 3: cross differences
  logic v2, v3;
  logic signed [2*EW-1:0] pa [3];
  logic signed [2*EW-1:0] pb [3];
  logic signed [CW-1:0] cr [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0; v3 <= 1'b0;
    end else if (adv) begin
      v2 <= v1; v3 <= v2;
      pa[0] <= e1[1] * e2[2]; pb[0] <= e1[2] * e2[1];
      pa[1] <= e1[2] * e2[0]; pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1]; pb[2] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++)
        cr[i] <= CW'(pa[i]) - CW'(pb[i]);
    end
  end

  // stage 4: magnitudes, signs, degenerate flag; their OR gives the leading-one position of the largest
  logic v4;
  logic [CW-1:0] mg4 [3];
  logic [2:0] sg4;
  logic [CW-1:0] or4;
  logic deg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) begin
      v4 <= v3;
      for (int i = 0; i < 3; i++) begin
        mg4[i] <= cr[i][CW-1] ? -cr[i] : cr[i];
        sg4[i] <= cr[i][CW-1];
      end
      deg4 <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
    end
  end
  assign or4 = mg4[0] | mg4[1] | mg4[2];

  // stage 5: normalise so the largest magnitude lies in [2^29, 2^30)
  logic v5;
  logic [29:0] mg5 [3];
  logic [2:0] sg5;
  logic deg5;
  logic [CSW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int b = 0; b < CW; b++)
      if (or4[b]) lead = CSW'(b);
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) begin
      v5 <= v4; sg5 <= sg4; deg5 <= deg4;
      for (int i = 0; i < 3; i++) begin
        if (lead >= CSW'(29)) mg5[i] <= 30'(mg4[i] >> (lead - CSW'(29)));
        else mg5[i] <= 30'({{30{1'b0}}, mg4[i]} << (CSW'(29) - lead));
      end
    end
  end

  // stage 6..: squares, then sum
  logic v6, v7;
  logic [59:0] sq6 [3];
  logic [29:0] mg6 [3], mg7 [3];
  logic [2:0] sg6, sg7;
  logic deg6, deg7;
  logic [SqW-1:0] sum7;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0; v7 <= 1'b0;
    end else if (adv) begin
      v6 <= v5; v7 <= v6;
      sg6 <= sg5; deg6 <= deg5; sg7 <= sg6; deg7 <= deg6;
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= mg5[i] * mg5[i];
        mg6[i] <= mg5[i]; mg7[i] <= mg6[i];
      end
      sum7 <= SqW'(sq6[0]) + SqW'(sq6[1]) + SqW'(sq6[2]);
    end
  end

  // square root: one result bit per stage
  logic            rv [NRT+1];
  logic [SqW-1:0]  rx [NRT+1];
  logic [RW-1:0]   rr [NRT+1];
  logic [29:0]     rm [NRT+1][3];
  logic [2:0]      rs [NRT+1];
  logic            rd [NRT+1];
  always_comb begin
    rv[0] = v7; rx[0] = sum7; rr[0] = '0; rs[0] = sg7; rd[0] = deg7;
    for (int i = 0; i < 3; i++) rm[0][i] = mg7[i];
  end
  for (genvar k = 0; k < NRT; k++) begin : g_root
    localparam int B = NRT - 1 - k;
    logic [SqW+1:0] trial;
    assign trial = ({{2{1'b0}}, rr[k]} << (B + 1)) + ((SqW+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (adv) begin
        rv[k+1] <= rv[k]; rs[k+1] <= rs[k]; rd[k+1] <= rd[k];
        for (int i = 0; i < 3; i++) rm[k+1][i] <= rm[k][i];
        if ({2'b00, rx[k]} >= trial) begin
          rx[k+1] <= SqW'({2'b00, rx[k]} - trial);
          rr[k+1] <= rr[k] | (RW'(1) << B);
        end else begin
          rx[k+1] <= rx[k];
          rr[k+1] <= rr[k];
        end
      end
    end
  end

  // divider setup: numerator (m << F) + r/2
  logic           dv [NDV+1];
  logic [RW-1:0]  dr [NDV+1];
  logic [NW-1:0]  dn [NDV+1][3];
  logic [QW-1:0]  dq [NDV+1][3];
  logic [2:0]     ds [NDV+1];
  logic           dd [NDV+1];
  always_comb begin
    dv[0] = rv[NRT]; dr[0] = rr[NRT]; ds[0] = rs[NRT]; dd[0] = rd[NRT];
    for (int i = 0; i < 3; i++) begin
      dn[0][i]  = (NW'(rm[NRT][i]) << F) + NW'(rr[NRT] >> 1);
      dq[0][i]  = '0;
    end
  end
  // restoring division, one quotient bit per stage (quotient fits QW bits)
  for (genvar k = 0; k < NDV; k++) begin : g_div
    localparam int B = NDV - 1 - k;
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) begin
        dv[k+1] <= dv[k]; dr[k+1] <= dr[k]; ds[k+1] <= ds[k]; dd[k+1] <= dd[k];
        for (int i = 0; i < 3; i++) begin
          if ((dn[k][i] >> B) >= NW'(dr[k]) && dr[k] != '0) begin
            dn[k+1][i] <= dn[k][i] - (NW'(dr[k]) << B);
            dq[k+1][i] <= dq[k][i] | (QW'(1) << B);
          end else begin
            dn[k+1][i] <= dn[k][i];
            dq[k+1][i] <= dq[k][i];
          end
        end
      end
    end
  end

  // dot product: signed normal times light
  logic vd1, vd2;
  logic signed [QW:0] nq [3];
  logic signed [PW-1:0] prod [3];
  logic signed [QW:0] nd [3];
  logic dg1, dg2;
  logic signed [PW+1:0] dot2;
  always_comb
    for (int i = 0; i < 3; i++)
      nq[i] = ds[NDV][i] ? -$signed({1'b0, dq[NDV][i]}) : $signed({1'b0, dq[NDV][i]});
  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0; vd2 <= 1'b0;
    end else if (adv) begin
      vd1 <= dv[NDV]; vd2 <= vd1; dg1 <= dd[NDV]; dg2 <= dg1;
      prod[0] <= nq[0] * light_x;
      prod[1] <= nq[1] * light_y;
      prod[2] <= nq[2] * light_z;
      for (int i = 0; i < 3; i++) begin
        nd[i] <= nq[i];
      end
      dot2 <= (PW+2)'(prod[0]) + (PW+2)'(prod[1]) + (PW+2)'(prod[2]);
    end
  end
  logic signed [QW:0] nd2 [3];
  always_ff @(posedge clk) if (adv) for (int i = 0; i < 3; i++) nd2[i] <= nd[i];

  // output register: rounding, floor and saturation
  logic [PW+1:0] itr;
  logic [14:0] inten;
  logic [15:0] ns [3];
  always_comb begin
    itr = dot2[PW+1] ? '0 :
          ((PW+2)'(dot2) + ((PW+2)'(1) << (F - 1))) >> F;
    if (itr > (PW+2)'(32767)) inten = 15'h7fff;
    else inten = 15'(itr);
    if (dot2 == '0 || inten < ambient_floor) inten = ambient_floor;
    if (dg2) inten = ambient_floor;
    for (int i = 0; i < 3; i++) begin
      if (dg2) ns[i] = '0;
      else if (longint'(nd2[i]) > 64'sd32767) ns[i] = 16'h7fff;
      else if (longint'(nd2[i]) < -64'sd32768) ns[i] = 16'h8000;
      else ns[i] = 16'(nd2[i]);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) begin
      m_tvalid <= vd2;
      m_tdata <= {dg2, inten, ns[2], ns[1], ns[0]};
    end
  end

  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_ready, clk, rst, m_tvalid && !m_tready, !s_tready)
  `ASSERT_IMPL(a_deg, clk, rst, m_tvalid && m_tdata[63], m_tdata[47:0] == 48'd0)
endmodule

// ===== tb/tfnl_checker.sv =====
// Checker for the triangle face normal lighting core: watches both streams,
// predicts normal and intensity per triangle, compares. Depends on tfnl_pkg.
module tfnl_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [tfnl_pkg::AddrW-1:0] paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  output int           fail_count,
  output int           pending,
  output int           shade_count,
  output int           flat_count
);
  typedef struct packed {
    logic                         degenerate;
    logic [tfnl_pkg::FloorW-1:0]  intensity;
    logic signed [15:0]           nz;
    logic signed [15:0]           ny;
    logic signed [15:0]           nx;
  } shade_t;

  logic signed [tfnl_pkg::LightW-1:0] lx, ly, lz;
  logic [tfnl_pkg::FloorW-1:0]        amb;
  shade_t                             shade_q[$];

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // predicted shading of one triangle
  function automatic shade_t shade_of(logic [143:0] d);
    longint vtx[9], e1[3], e2[3], cr[3], nrm[3], dot;
    longint unsigned mg[3], mx, r, q, it;
    bit up;
    shade_t s;
    for (int i = 0; i < 9; i++) vtx[i] = longint'($signed(d[16*i +: 16]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = vtx[3+i] - vtx[i];
      e2[i] = vtx[6+i] - vtx[i];
    end
    cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
    cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
    cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
    s = '0;
    if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
      s.intensity = amb;
      s.degenerate = 1'b1;
      return s;
    end
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (mg[i] > mx) mx = mg[i];
    end
    // bring the largest magnitude into [2^29, 2^30)
    up = mx < (64'd1 << 29);
    while (mx >= (64'd1 << 30) || mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mg[i] = up ? mg[i] << 1 : mg[i] >> 1;
      mx = up ? mx << 1 : mx >> 1;
    end
    r = root64(mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 14) + (r >> 1)) / r;
      nrm[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
    end
    dot = nrm[0]*longint'(lx) + nrm[1]*longint'(ly) + nrm[2]*longint'(lz);
    it = 0;
    if (dot > 0) it = (unsigned'(dot) + (64'd1 << 13)) >> 14;
    if (it < amb) it = amb;
    if (it > 32767) it = 32767;
    s.nx = sat16(nrm[0]);
    s.ny = sat16(nrm[1]);
    s.nz = sat16(nrm[2]);
    s.intensity = it[tfnl_pkg::FloorW-1:0];
    return s;
  endfunction

  assign pending = shade_q.size();

  always @(posedge clk) begin
    shade_t exp_s, got;
    if (rst) begin
      lx <= '0;
      ly <= '0;
      lz <= 16'sd16384;
      amb <= 15'd1638;
      shade_q.delete();
      fail_count <= 0;
      shade_count <= 0;
      flat_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite) begin
        case (tfnl_pkg::reg_idx_t'(paddr[3:2]))
          tfnl_pkg::REG_LIGHT_X: lx <= pwdata[15:0];
          tfnl_pkg::REG_LIGHT_Y: ly <= pwdata[15:0];
          tfnl_pkg::REG_LIGHT_Z: lz <= pwdata[15:0];
          tfnl_pkg::REG_FLOOR:   amb <= pwdata[14:0];
          default: ;
        endcase
      end
      // triangle requests
      if (s_tvalid && s_tready) begin
        exp_s = shade_of(s_tdata);
        shade_q.push_back(exp_s);
        if (exp_s.degenerate) flat_count <= flat_count + 1;
      end
      // results
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        shade_count <= shade_count + 1;
        if (shade_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_s = shade_q.pop_front();
          if (got != exp_s) begin
            if (fail_count < 10)
              $display({"mismatch: exp n=(%0d,%0d,%0d) i=%0d d=%0b",
                        " got n=(%0d,%0d,%0d) i=%0d d=%0b"},
                       exp_s.nx, exp_s.ny, exp_s.nz, exp_s.intensity, exp_s.degenerate,
                       got.nx, got.ny, got.nz, got.intensity, got.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the lighting core testbench: clock, reset, register writes,
// triangle stimulus and verdict. Depends on tfnl_pkg, tfnl_checker and the lighting core.
module testbench;
  localparam int LATENCY = 60;
  localparam int WATCHDOG = 20000;

  logic         clk, rst;
  logic         psel, penable, pwrite;
  logic [tfnl_pkg::AddrW-1:0] paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;
  logic         s_tvalid, s_tready;
  logic [143:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [63:0]  m_tdata;
  int           fail_count, pending, shade_count, flat_count;
  int           idle_cycles;
  bit           hold_off;

  triangle_face_normal_lighting_core u_dut (.*);

  tfnl_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any accepted request or result or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int mode;
    bit held;
    held = 0;
    m_tready = 0;
    @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        held = 1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= $urandom_range(0, 1);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic reg_write(tfnl_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= tfnl_pkg::AddrW'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_light(int x, int y, int z, int fl);
    reg_write(tfnl_pkg::REG_LIGHT_X, x);
    reg_write(tfnl_pkg::REG_LIGHT_Y, y);
    reg_write(tfnl_pkg::REG_LIGHT_Z, z);
    reg_write(tfnl_pkg::REG_FLOOR, fl);
  endtask

  // wait for every result, then let the pipeline drain
  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // offer one triangle; random gap before it in bursty fashion
  task automatic send_tri(logic [143:0] d, bit gappy);
    if (gappy && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // random triangle; some degenerate on purpose
  function automatic logic [143:0] rnd_tri();
    logic [143:0] d;
    int mode, k, a, b;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) d[16*i +: 16] = rnd_coord(mode);
    k = $urandom_range(0, 9);
    if (k == 0) d[143:48] = {3{d[47:0]}};
    else if (k == 1) d[143:96] = d[95:48];
    else if (k == 2) begin
      // collinear: quarter A and B, then C = 2B - A
      for (int i = 0; i < 3; i++) begin
        a = $signed(d[16*i +: 16]) / 4;
        b = $signed(d[48+16*i +: 16]) / 4;
        d[16*i +: 16] = 16'(a);
        d[48+16*i +: 16] = 16'(b);
        d[96+16*i +: 16] = 16'(2 * b - a);
      end
    end
    return d;
  endfunction

  function automatic logic [143:0] tri_of(int a0, int a1, int a2, int b0, int b1,
                                         int b2, int c0, int c1, int c2);
    return {16'(c2), 16'(c1), 16'(c0), 16'(b2), 16'(b1), 16'(b0),
            16'(a2), 16'(a1), 16'(a0)};
  endfunction

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0; hold_off = 0;
    rst = 1;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: axis faces, extremes, degenerate cases at reset settings
    send_tri(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
    send_tri(tri_of(0, 0, 0, 0, 256, 0, 256, 0, 0), 0);
    send_tri(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256), 0);
    send_tri(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0), 0);
    send_tri(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
    send_tri(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                    -32768, 32767, 32767), 0);
    send_tri(tri_of(32767, 32767, 32767, -32768, 32767, -32768,
                    32767, -32768, -32768), 0);
    send_tri(tri_of(-32768, 32767, -32768, 32767, -32768, 32767,
                    -32768, -32768, 32767), 0);
    send_tri(tri_of(5, 5, 5, 5, 5, 5, 5, 5, 5), 0);
    send_tri(tri_of(0, 0, 0, 100, 100, 100, 200, 200, 200), 0);
    send_tri(tri_of(1, 2, 3, 1, 2, 3, 9, 9, 9), 0);
    send_tri(tri_of(0, 0, 0, 3, 1, 0, 1, 3, 1), 0);
    drain();

    // light extremes and floors
    set_light(16384, 0, 0, 0);
    send_tri(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256), 0);
    send_tri(tri_of(0, 0, 0, 0, 0, 256, 0, 256, 0), 0);
    send_tri(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    drain();
    set_light(-16384, -16384, -16384, 16384);
    send_tri(tri_of(0, 0, 0, 0, 256, 0, 0, 0, 256), 0);
    send_tri(tri_of(0, 0, 0, 256, 256, 0, 0, 0, 256), 0);
    drain();
    set_light(0, -16384, 0, 32767);
    send_tri(tri_of(0, 0, 0, 0, 0, 256, 256, 0, 0), 0);
    send_tri(tri_of(0, 0, 0, 1, 1, 1, 2, 2, 2), 0);
    drain();

    // random phases with varied light directions, incl. raw bit patterns
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_light(9459, 9459, 9459, 1638);
        1: set_light(-9459, 9459, -9459, 0);
        2: set_light($urandom, $urandom, $urandom, $urandom);
        3: set_light(32767, 32767, 32767, 0);
        4: set_light(-32768, -32768, -32768, 32767);
        5: set_light(16384, 0, 0, 16384);
        default: set_light(0, 0, 16384, 1638);
      endcase
      for (int n = 0; n < 200; n++) begin
        if (ph == 2 && n == 50) hold_off = 1;
        send_tri(rnd_tri(), 1);
      end
      drain();
    end

    $display("covered %0d results, %0d degenerate, over 11 light settings",
             shade_count, flat_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
